/* sv/pbkf_pkg.sv */
// Shared types, constants, saturation helpers and the update microprogram.
package pbkf_pkg;

  localparam int DW    = 48;        // data width, signed Q23.24
  localparam int FB    = 24;        // fraction bits
  localparam int HW    = DW / 2;    // partial-product half width
  localparam int QW    = DW + FB;   // unsaturated quotient / shifted product width
  localparam int CW    = 47;        // configuration register width
  localparam int TW    = 25;        // time step width
  localparam int SW    = 5;         // step counter width
  localparam int NSTEP = 20;        // microprogram length

  typedef logic signed [DW-1:0] val_t;

  localparam val_t VMAX = val_t'({1'b0, {(DW-1){1'b1}}});
  localparam val_t VMIN = val_t'({1'b1, {(DW-1){1'b0}}});
  localparam logic [QW-1:0] QNEG_LIM = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] QPOS_LIM = QNEG_LIM - QW'(1);
  localparam logic [TW-1:0] DT_ONE   = TW'(1) << FB;

  localparam logic [1:0] CFG_QP = 2'd0;
  localparam logic [1:0] CFG_QB = 2'd1;
  localparam logic [1:0] CFG_RM = 2'd2;

  localparam logic [CW-1:0] QP_RST = CW'(16777);
  localparam logic [CW-1:0] QB_RST = CW'(50332);
  localparam logic [CW-1:0] RM_RST = CW'(503316);

  typedef enum logic [1:0] {OP_ADD, OP_MAC, OP_DIV} op_e;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_MP, SRC_MR, SRC_DT, SRC_QP, SRC_QB, SRC_RM, SRC_PE, SRC_BIAS,
    SRC_P0, SRC_P1, SRC_P2, SRC_P3, SRC_PRED, SRC_T, SRC_DP, SRC_S, SRC_K0,
    SRC_K1, SRC_Y
  } src_e;

  // ADD: dst = c +/- b ; MAC: dst = c +/- a*b ; DIV: dst = a / b
  typedef struct packed {
    op_e  op;
    logic sub;
    src_e a;
    src_e b;
    src_e c;
    src_e dst;
  } uop_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic publish;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic done;
  } status_t;

  function automatic val_t sat_add(val_t x, val_t y, logic sub);
    logic signed [DW:0] s;
    s = sub ? ({x[DW-1], x} - {y[DW-1], y}) : ({x[DW-1], x} + {y[DW-1], y});
    if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
    return s[DW-1:0];
  endfunction

  // Magnitude with sign to saturated signed value.
  function automatic val_t sat_mag(logic [QW-1:0] q, logic neg);
    if (neg) begin
      if (q > QNEG_LIM) return VMIN;
      return val_t'(~q[DW-1:0] + 1'b1);
    end
    if (q > QPOS_LIM) return VMAX;
    return val_t'(q[DW-1:0]);
  endfunction

  function automatic uop_t mk(op_e op, logic sub, src_e a, src_e b, src_e c, src_e d);
    uop_t u;
    u.op  = op;
    u.sub = sub;
    u.a   = a;
    u.b   = b;
    u.c   = c;
    u.dst = d;
    return u;
  endfunction

  function automatic uop_t uop_at(logic [SW-1:0] k);
    uop_t u;
    unique case (k)
      5'd0:  u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_BIAS, SRC_MR,   SRC_T);
      5'd1:  u = mk(OP_MAC, 1'b0, SRC_T,    SRC_DT,   SRC_PE,   SRC_PRED);
      5'd2:  u = mk(OP_MAC, 1'b0, SRC_DT,   SRC_P3,   SRC_ZERO, SRC_DP);
      5'd3:  u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_P1,   SRC_DP,   SRC_T);
      5'd4:  u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_P2,   SRC_T,    SRC_T);
      5'd5:  u = mk(OP_ADD, 1'b0, SRC_ZERO, SRC_QP,   SRC_T,    SRC_T);
      5'd6:  u = mk(OP_MAC, 1'b0, SRC_DT,   SRC_T,    SRC_P0,   SRC_P0);
      5'd7:  u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_DP,   SRC_P1,   SRC_P1);
      5'd8:  u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_DP,   SRC_P2,   SRC_P2);
      5'd9:  u = mk(OP_MAC, 1'b0, SRC_QB,   SRC_DT,   SRC_P3,   SRC_P3);
      5'd10: u = mk(OP_ADD, 1'b0, SRC_ZERO, SRC_RM,   SRC_P0,   SRC_S);
      5'd11: u = mk(OP_DIV, 1'b0, SRC_P0,   SRC_S,    SRC_ZERO, SRC_K0);
      5'd12: u = mk(OP_DIV, 1'b0, SRC_P2,   SRC_S,    SRC_ZERO, SRC_K1);
      5'd13: u = mk(OP_ADD, 1'b1, SRC_ZERO, SRC_PRED, SRC_MP,   SRC_Y);
      5'd14: u = mk(OP_MAC, 1'b0, SRC_K0,   SRC_Y,    SRC_PRED, SRC_PE);
      5'd15: u = mk(OP_MAC, 1'b0, SRC_K1,   SRC_Y,    SRC_BIAS, SRC_BIAS);
      // cross terms first so they still see the predicted P0 and P1
      5'd16: u = mk(OP_MAC, 1'b1, SRC_K1,   SRC_P0,   SRC_P2,   SRC_P2);
      5'd17: u = mk(OP_MAC, 1'b1, SRC_K1,   SRC_P1,   SRC_P3,   SRC_P3);
      5'd18: u = mk(OP_MAC, 1'b1, SRC_K0,   SRC_P0,   SRC_P0,   SRC_P0);
      5'd19: u = mk(OP_MAC, 1'b1, SRC_K0,   SRC_P1,   SRC_P1,   SRC_P1);
      default: u = mk(OP_ADD, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO);
    endcase
    return u;
  endfunction

endpackage

/* sv/pbkf_mul.sv */
// Fixed-point multiplier: four half-width partial products, saturated result.
module pbkf_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pbkf_pkg::val_t a_i,
  input  pbkf_pkg::val_t b_i,
  output logic          done_o,
  output pbkf_pkg::val_t res_o
);
  import pbkf_pkg::*;

  logic            busy_q, done_q;
  logic [2:0]      cnt_q;
  logic [DW-1:0]   ma_q, mb_q;
  logic            neg_q;
  logic [DW-1:0]   pp_q;
  logic [1:0]      sh_q;
  logic [2*DW-1:0] acc_q;
  val_t            res_q;
  logic [HW-1:0]   ha, hb;
  logic [DW-1:0]   prod;
  logic [2*DW-1:0] pp_sh;

  assign ha   = cnt_q[1] ? ma_q[DW-1:HW] : ma_q[HW-1:0];
  assign hb   = cnt_q[0] ? mb_q[DW-1:HW] : mb_q[HW-1:0];
  assign prod = DW'(ha) * DW'(hb);

  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = {{DW{1'b0}}, pp_q};
      2'd1:    pp_sh = {{HW{1'b0}}, pp_q, {HW{1'b0}}};
      default: pp_sh = {pp_q, {DW{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[DW-1] ? (~a_i + 1'b1) : a_i;
      mb_q  <= b_i[DW-1] ? (~b_i + 1'b1) : b_i;
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= prod;
        sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + pp_sh;
      if (cnt_q == 3'd5) res_q <= sat_mag(acc_q[2*DW-1:FB], neg_q);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/pbkf_div.sv */
// Fixed-point divider: restoring, two quotient bits per cycle, saturated result, zero for a zero divisor.
module pbkf_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pbkf_pkg::val_t n_i,
  input  pbkf_pkg::val_t d_i,
  output logic          done_o,
  output pbkf_pkg::val_t res_o
);
  import pbkf_pkg::*;

  localparam int NIT = QW / 2;

  logic          busy_q, done_q;
  logic [5:0]    cnt_q;
  logic [QW-1:0] dv_q;
  logic [DW-1:0] r_q, md_q;
  logic          neg_q, zero_q;
  val_t          res_q;
  logic [DW:0]   r_a, r_a2, r_b, r_b2;
  logic          ge_a, ge_b;

  always_comb begin
    r_a  = {r_q, dv_q[QW-1]};
    ge_a = r_a >= {1'b0, md_q};
    r_a2 = ge_a ? (r_a - {1'b0, md_q}) : r_a;
    r_b  = {r_a2[DW-1:0], dv_q[QW-2]};
    ge_b = r_b >= {1'b0, md_q};
    r_b2 = ge_b ? (r_b - {1'b0, md_q}) : r_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(NIT)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q   <= {(n_i[DW-1] ? (~n_i + 1'b1) : n_i), {FB{1'b0}}};
      md_q   <= d_i[DW-1] ? (~d_i + 1'b1) : d_i;
      neg_q  <= n_i[DW-1] ^ d_i[DW-1];
      zero_q <= (d_i == '0);
      r_q    <= '0;
    end else if (busy_q) begin
      if (cnt_q < 6'(NIT)) begin
        dv_q <= {dv_q[QW-3:0], ge_a, ge_b};
        r_q  <= r_b2[DW-1:0];
      end else begin
        res_q <= zero_q ? val_t'(0) : sat_mag(dv_q, neg_q);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/pbkf_dpath.sv */
// Datapath: filter state, configuration, operand selection, arithmetic units.
module pbkf_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pbkf_pkg::cmd_t            cmd_i,
  output pbkf_pkg::status_t         status_o,
  input  pbkf_pkg::val_t            mp_i,
  input  pbkf_pkg::val_t            mr_i,
  input  logic [pbkf_pkg::TW-1:0]   ts_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [pbkf_pkg::CW-1:0]   cfg_data_i,
  output pbkf_pkg::val_t            pe_o,
  output pbkf_pkg::val_t            bias_o
);
  import pbkf_pkg::*;

  val_t mp_q, mr_q, dt_q;
  logic [CW-1:0] qp_q, qb_q, rm_q;
  val_t pe_q, bias_q, p0_q, p1_q, p2_q, p3_q;
  val_t pred_q, t_q, dp_q, s_q, k0_q, k1_q, y_q;
  val_t out_pe_q, out_bias_q;
  uop_t uop_q;
  logic go_q;
  val_t opa, opb, opc, wr_val, mul_res, div_res;
  logic wr_en, mul_done, div_done, mul_go, div_go;
  logic [TW-1:0] dt_clamp;

  function automatic val_t rd(src_e s, val_t mp, val_t mr, val_t dt, logic [CW-1:0] qp,
                               logic [CW-1:0] qb, logic [CW-1:0] rm, val_t pe, val_t bias,
                               val_t p0, val_t p1, val_t p2, val_t p3, val_t pred, val_t t,
                               val_t dp, val_t sv, val_t k0, val_t k1, val_t y);
    case (s)
      SRC_MP:   return mp;
      SRC_MR:   return mr;
      SRC_DT:   return dt;
      SRC_QP:   return val_t'({1'b0, qp});
      SRC_QB:   return val_t'({1'b0, qb});
      SRC_RM:   return val_t'({1'b0, rm});
      SRC_PE:   return pe;
      SRC_BIAS: return bias;
      SRC_P0:   return p0;
      SRC_P1:   return p1;
      SRC_P2:   return p2;
      SRC_P3:   return p3;
      SRC_PRED: return pred;
      SRC_T:    return t;
      SRC_DP:   return dp;
      SRC_S:    return sv;
      SRC_K0:   return k0;
      SRC_K1:   return k1;
      SRC_Y:    return y;
      default:  return val_t'(0);
    endcase
  endfunction

  always_comb begin
    opa = rd(uop_q.a, mp_q, mr_q, dt_q, qp_q, qb_q, rm_q, pe_q, bias_q, p0_q, p1_q, p2_q,
             p3_q, pred_q, t_q, dp_q, s_q, k0_q, k1_q, y_q);
    opb = rd(uop_q.b, mp_q, mr_q, dt_q, qp_q, qb_q, rm_q, pe_q, bias_q, p0_q, p1_q, p2_q,
             p3_q, pred_q, t_q, dp_q, s_q, k0_q, k1_q, y_q);
    opc = rd(uop_q.c, mp_q, mr_q, dt_q, qp_q, qb_q, rm_q, pe_q, bias_q, p0_q, p1_q, p2_q,
             p3_q, pred_q, t_q, dp_q, s_q, k0_q, k1_q, y_q);
  end

  assign mul_go = go_q && (uop_q.op == OP_MAC);
  assign div_go = go_q && (uop_q.op == OP_DIV);

  pbkf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pbkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .n_i     (opa),
    .d_i     (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    wr_en  = 1'b0;
    wr_val = div_res;
    if (go_q && uop_q.op == OP_ADD) begin
      wr_en  = 1'b1;
      wr_val = sat_add(opc, opb, uop_q.sub);
    end else if (mul_done) begin
      wr_en  = 1'b1;
      wr_val = sat_add(opc, mul_res, uop_q.sub);
    end else if (div_done) begin
      wr_en  = 1'b1;
    end
  end

  assign status_o.done = (go_q && uop_q.op == OP_ADD) || mul_done || div_done;
  assign dt_clamp      = (ts_i > DT_ONE) ? DT_ONE : ts_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
      qp_q <= QP_RST;
      qb_q <= QB_RST;
      rm_q <= RM_RST;
    end else begin
      go_q <= cmd_i.issue;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_QP:  qp_q <= cfg_data_i;
          CFG_QB:  qb_q <= cfg_data_i;
          CFG_RM:  rm_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q   <= '0;
      bias_q <= '0;
      p0_q   <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= '0;
    end else if (wr_en) begin
      case (uop_q.dst)
        SRC_PE:   pe_q   <= wr_val;
        SRC_BIAS: bias_q <= wr_val;
        SRC_P0:   p0_q   <= wr_val;
        SRC_P1:   p1_q   <= wr_val;
        SRC_P2:   p2_q   <= wr_val;
        SRC_P3:   p3_q   <= wr_val;
        default:  ;
      endcase
    end
  end

  // item operands, scratch values, result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) uop_q <= cmd_i.uop;
    if (cmd_i.load) begin
      mp_q <= mp_i;
      mr_q <= mr_i;
      dt_q <= val_t'({{(DW-TW){1'b0}}, dt_clamp});
    end
    if (cmd_i.publish) begin
      out_pe_q   <= pe_q;
      out_bias_q <= bias_q;
    end
    if (wr_en) begin
      case (uop_q.dst)
        SRC_PRED: pred_q <= wr_val;
        SRC_T:    t_q    <= wr_val;
        SRC_DP:   dp_q   <= wr_val;
        SRC_S:    s_q    <= wr_val;
        SRC_K0:   k0_q   <= wr_val;
        SRC_K1:   k1_q   <= wr_val;
        SRC_Y:    y_q    <= wr_val;
        default:  ;
      endcase
    end
  end

  assign pe_o   = out_pe_q;
  assign bias_o = out_bias_q;

endmodule

/* sv/pbkf_ctrl.sv */
// Controller: steps the update microprogram and runs the item handshakes.
module pbkf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pbkf_pkg::cmd_t      cmd_o,
  input  pbkf_pkg::status_t   status_i
);
  import pbkf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_e;

  state_e        state_q;
  logic [SW-1:0] step_q;
  logic          out_valid_q;
  logic          publish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign publish     = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.load    = in_valid_i && (state_q == S_IDLE);
    cmd_o.issue   = (state_q == S_ISSUE);
    cmd_o.publish = publish;
    cmd_o.uop     = uop_at(step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (publish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            step_q  <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (status_i.done) begin
            if (step_q == SW'(NSTEP - 1)) begin
              state_q <= S_FINISH;
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          // hold until the result register is free
          if (publish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/pressure_bias_kalman_filter.sv */
// Two-state pressure / rate-bias Kalman filter, Q23.24 saturating fixed point.
// One item at a time: a new item is accepted only once the last result is published.
// Each update runs 20 microsteps: 8 adds, 10 multiplies on one shared four-pass
// multiplier, and 2 divides on one radix-4 divider.
// Publishing waits while an unaccepted result holds the result register.
// Reset clears estimate, bias and covariance and loads the default noise registers.
module pressure_bias_kalman_filter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // measured_pressure, measured_rate, time_step
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // estimated_pressure, estimated_bias
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [46:0]  cfg_data_i
);
  import pbkf_pkg::*;

  cmd_t    cmd;
  status_t status;
  val_t    pe, bias;

  assign cfg_ready_o = 1'b1;

  pbkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  pbkf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mp_i        (val_t'(s_axis_tdata[47:0])),
    .mr_i        (val_t'(s_axis_tdata[95:48])),
    .ts_i        (s_axis_tdata[120:96]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pe_o        (pe),
    .bias_o      (bias)
  );

  assign m_axis_tdata = {bias, pe};

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the pressure / rate-bias Kalman filter.
`timescale 1ns / 1ps

module testbench;
  import pbkf_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     DRAIN_CYCLES = 400;
  localparam longint DMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DMIN = -DMAX - 1;
  localparam logic [46:0] NOISE_MAX = {47{1'b1}};

  typedef struct {
    val_t pressure;
    val_t bias;
  } estimate_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [46:0]  cfg_data_i;

  // filter state held by the predictor
  longint      est_pressure;
  longint      est_bias;
  longint      cov [4];
  logic [46:0] noise_p;
  logic [46:0] noise_b;
  logic [46:0] noise_m;

  estimate_t   pending_estimates [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          failed;
  longint      cycle_count;

  pressure_bias_kalman_filter DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint sat48(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  function automatic longint from_mag(logic [127:0] m, bit neg);
    if (neg) return (m > 128'(DMAX) + 1) ? DMIN : -longint'(m[63:0]);
    return (m > 128'(DMAX)) ? DMAX : longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] magnitude(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = (magnitude(a) * magnitude(b)) >> FB;
    return from_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint n, longint d);
    logic [127:0] q;
    if (d == 0) return 0;
    q = (magnitude(n) << FB) / magnitude(d);
    return from_mag(q, (n < 0) != (d < 0));
  endfunction

  // Advance the filter by one measurement and return the corrected estimate.
  function automatic estimate_t filter_update(logic [47:0] mp_raw, logic [47:0] mr_raw,
                                              logic [24:0] ts_raw);
    longint mp, mr, dt, rate, pred, t, dp11, s, k0, k1, y, p00, p01;
    estimate_t e;
    mp = longint'($signed(mp_raw));
    mr = longint'($signed(mr_raw));
    dt = (ts_raw > 25'(DT_ONE)) ? longint'(DT_ONE) : longint'(ts_raw);
    rate = sat48(mr - est_bias);
    pred = sat48(est_pressure + q_mul(rate, dt));
    t = q_mul(dt, cov[3]);
    t = sat48(t - cov[1]);
    t = sat48(t - cov[2]);
    t = sat48(t + longint'(noise_p));
    cov[0] = sat48(cov[0] + q_mul(dt, t));
    dp11 = q_mul(dt, cov[3]);
    cov[1] = sat48(cov[1] - dp11);
    cov[2] = sat48(cov[2] - dp11);
    cov[3] = sat48(cov[3] + q_mul(longint'(noise_b), dt));
    s = sat48(cov[0] + longint'(noise_m));
    k0 = q_div(cov[0], s);
    k1 = q_div(cov[2], s);
    y = sat48(mp - pred);
    est_pressure = sat48(pred + q_mul(k0, y));
    est_bias = sat48(est_bias + q_mul(k1, y));
    p00 = cov[0];
    p01 = cov[1];
    cov[0] = sat48(cov[0] - q_mul(k0, p00));
    cov[1] = sat48(cov[1] - q_mul(k0, p01));
    cov[2] = sat48(cov[2] - q_mul(k1, p00));
    cov[3] = sat48(cov[3] - q_mul(k1, p01));
    e.pressure = val_t'(est_pressure);
    e.bias = val_t'(est_bias);
    return e;
  endfunction

  task automatic send_sample(logic [47:0] mp, logic [47:0] mr, logic [24:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ts, mr, mp};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_estimates.push_back(filter_update(mp, mr, ts));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_noise(logic [1:0] idx, logic [46:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_QP: noise_p = value;
      CFG_QB: noise_b = value;
      default: noise_m = value;
    endcase
  endtask

  task automatic set_noise(logic [46:0] qp, logic [46:0] qb, logic [46:0] rm);
    write_noise(CFG_QP, qp);
    write_noise(CFG_QB, qb);
    write_noise(CFG_RM, rm);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  task automatic test_default_extremes();
    send_sample(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 25'd0);
    send_sample(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 25'(DT_ONE));
    send_sample(48'h0, 48'h0, 25'h1FF_FFFF);              // clamp to one second
    send_sample(48'hFFFF_FFFF_FFFF, 48'h1, 25'd1);
    send_sample(48'h0100_0000, 48'hFF00_0000_0000, 25'(DT_ONE) + 25'd1);
    send_sample(48'hFFFF_FF00_0000, 48'h7FFF_FFFF_FFFF, 25'h100_0000);
  endtask

  task automatic test_zero_innovation();
    // all three noise values set to zero; covariance is not reset by this test
    set_noise(47'd0, 47'd0, 47'd0);
    send_sample(48'h7FFF_FFFF_FFFF, 48'h0000_0100_0000, 25'd0);
    send_sample(48'h8000_0000_0000, 48'h8000_0000_0000, 25'(DT_ONE));
    send_sample(48'h1234_5678_9ABC, 48'h0, 25'h80_0000);
  endtask

  task automatic test_noise_extremes();
    set_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX);
    send_sample(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 25'(DT_ONE));
    send_sample(48'h8000_0000_0000, 48'h8000_0000_0000, 25'h1FF_FFFF);
    send_sample(48'h0, 48'h0, 25'd1);
    set_noise(NOISE_MAX, 47'd1, 47'd0);
    send_sample(48'h0000_0200_0000, 48'h0, 25'(DT_ONE));
    send_sample(48'hFFFF_FE00_0000, 48'h7FFF_FFFF_FFFF, 25'h40_0000);
    send_sample(48'h8000_0000_0000, 48'h8000_0000_0000, 25'd0);
    set_noise(47'd1, NOISE_MAX, 47'd1);
    send_sample(48'h0000_0100_0000, 48'h0000_0080_0000, 25'(DT_ONE));
    send_sample(48'h7FFF_FFFF_FFFF, 48'h0, 25'(DT_ONE));
  endtask

  // Mostly a slowly moving pressure with plausible rate; some wild items.
  task automatic test_random_track(int count);
    longint level;
    logic [47:0] mp, mr;
    logic [24:0] ts;
    level = longint'($signed(rand48())) >>> $urandom_range(24);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 80) begin
        level = sat48(level + (longint'($signed(32'($urandom))) >>> $urandom_range(8, 31)));
        mp = 48'(level + (longint'($signed(32'($urandom))) >>> $urandom_range(4, 31)));
        mr = 48'(longint'($signed(32'($urandom))) >>> $urandom_range(0, 20));
        ts = 25'($urandom_range(0, 32'(DT_ONE)));
      end else begin
        mp = rand48();
        mr = rand48();
        ts = 25'($urandom);
      end
      send_sample(mp, mr, ts);
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 15;
    recv_idle_pct = 56;
    test_random_track(545);
    set_noise(47'(16777), 47'(50332), 47'(503316));
    send_idle_pct = 56;
    recv_idle_pct = 15;
    test_random_track(545);
    set_noise(47'({$urandom, $urandom} >> $urandom_range(0, 46)),
              47'({$urandom, $urandom} >> $urandom_range(0, 46)),
              47'({$urandom, $urandom} >> $urandom_range(0, 46)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_track(545);
  endtask

  // Check each result, then pick the next ready.
  always @(posedge clk_i) begin
    estimate_t exp_e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_estimates.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_e = pending_estimates.pop_front();
        if (m_axis_tdata[47:0] !== exp_e.pressure) begin
          $error("estimated_pressure expected %h actual %h", exp_e.pressure,
                 m_axis_tdata[47:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[95:48] !== exp_e.bias) begin
          $error("estimated_bias expected %h actual %h", exp_e.bias, m_axis_tdata[95:48]);
          failed = 1'b1;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    failed = 1'b0;
    cycle_count = 0;
    send_idle_pct = 15;
    recv_idle_pct = 56;
    est_pressure = 0;
    est_bias = 0;
    foreach (cov[i]) cov[i] = 0;
    noise_p = QP_RST;
    noise_b = QB_RST;
    noise_m = RM_RST;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_QP;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_extremes();
    test_zero_innovation();
    test_noise_extremes();
    test_random_phases();
    wait_idle();
    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
